/* rtl/pbl_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package pbl_pkg;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_LOOKUP = 1'b1;

    localparam int DEG_W   = 9;
    localparam int AFRAC_W = 16;
    localparam int SFRAC_W = 8;
    localparam int WS_W    = 15;

    localparam int QDEPTH          = 4;
    localparam int QPTR_W          = 2;
    localparam int QCNT_W          = 3;
    localparam int MAX_OUTSTANDING = QDEPTH + 2;

    localparam logic [1:0] STEP_R0C0 = 2'd0;
    localparam logic [1:0] STEP_R1C0 = 2'd1;
    localparam logic [1:0] STEP_R0C1 = 2'd2;
    localparam logic [1:0] STEP_R1C1 = 2'd3;

    typedef struct packed {
        logic               is_write;
        logic               wr_ok;
        logic [AFRAC_W-1:0] afrac;
        logic [SFRAC_W-1:0] sfrac;
    } job_ctl_t;

    typedef struct packed {
        logic               vld;
        logic [1:0]         step;
        logic [AFRAC_W-1:0] afrac;
        logic [SFRAC_W-1:0] sfrac;
    } rd_tag_t;

endpackage

`default_nettype wire

/* rtl/pbl_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module pbl_front #(
    parameter int ANGLE_ROWS    = 181,
    parameter int SPEED_COLUMNS = 61,
    parameter int ENTRY_BITS    = 16,
    localparam int ROW_W        = $clog2(ANGLE_ROWS),
    localparam int COL_W        = $clog2(SPEED_COLUMNS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  req_type,
    input  logic [7:0]            angle_row,
    input  logic [5:0]            speed_column,
    input  logic [15:0]           entry_value,
    input  logic [15:0]           wind_bearing,
    input  logic [13:0]           wind_knots,
    input  logic                  mode,
    input  logic                  take,
    output logic                  job_vld,
    output pbl_pkg::job_ctl_t     job_ctl,
    output logic [ROW_W-1:0]      job_row,
    output logic [ROW_W-1:0]      job_row2,
    output logic [COL_W-1:0]      job_col,
    output logic [COL_W-1:0]      job_col2,
    output logic [ENTRY_BITS-1:0] job_wdata
);

    import pbl_pkg::*;

    localparam int LAST_ROW = ANGLE_ROWS - 1;
    localparam int LAST_COL = SPEED_COLUMNS - 1;
    localparam logic [DEG_W-1:0] LAST_ROW_D = DEG_W'(LAST_ROW);
    localparam logic [6:0]       LAST_COL_D = 7'(LAST_COL);
    localparam logic [WS_W-1:0]  WS_MAX     = WS_W'(LAST_COL * 256);

    logic        a_vld_reg, a_vld_next;
    logic        a_type_reg;
    logic [7:0]  a_row_reg;
    logic [5:0]  a_col_reg;
    logic [15:0] a_val_reg;
    logic [15:0] a_ang_reg;
    logic [13:0] a_ws_reg;
    logic        accept;

    logic [15:0]        half_ang;
    logic [24:0]        t_lin;
    logic [24:0]        t_rnd;
    logic [DEG_W-1:0]   deg_lin;
    logic [DEG_W-1:0]   deg_rnd_raw;
    logic [DEG_W-1:0]   deg_rnd;
    logic [DEG_W-1:0]   row_d;
    logic [DEG_W-1:0]   row2_d;
    logic [AFRAC_W-1:0] afrac;
    logic [WS_W-1:0]    ws_sat;
    logic [6:0]         col_d;
    logic [6:0]         col2_d;
    logic [SFRAC_W-1:0] sfrac;
    logic               wr_ok;

    assign in_stall   = a_vld_reg && !take;
    assign accept     = in_valid && !in_stall;
    assign a_vld_next = accept ? 1'b1 : (take ? 1'b0 : a_vld_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= a_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            a_type_reg <= req_type;
            a_row_reg  <= angle_row;
            a_col_reg  <= speed_column;
            a_val_reg  <= entry_value;
            a_ang_reg  <= wind_bearing;
            a_ws_reg   <= wind_knots;
        end
    end

    always_comb
    begin
        half_ang    = (a_ang_reg > 16'd32768) ? 16'(17'd65536 - {1'b0, a_ang_reg}) : a_ang_reg;
        t_lin       = 25'(half_ang) * 25'd360;
        deg_lin     = t_lin[24:16];
        t_rnd       = 25'(a_ang_reg) * 25'd360 + 25'd32768;
        deg_rnd_raw = t_rnd[24:16];
        deg_rnd     = (deg_rnd_raw > 9'd180) ? 9'd360 - deg_rnd_raw : deg_rnd_raw;

        if (mode)
        begin
            row_d  = (deg_rnd > LAST_ROW_D) ? LAST_ROW_D : deg_rnd;
            row2_d = row_d;
            afrac  = '0;
        end
        else if (deg_lin >= LAST_ROW_D)
        begin
            row_d  = LAST_ROW_D;
            row2_d = LAST_ROW_D - 9'd1;
            afrac  = '0;
        end
        else
        begin
            row_d  = deg_lin;
            row2_d = deg_lin + 9'd1;
            afrac  = t_lin[15:0];
        end

        ws_sat = ({1'b0, a_ws_reg} > WS_MAX) ? WS_MAX : {1'b0, a_ws_reg};
        if (ws_sat[14:8] >= LAST_COL_D)
        begin
            col_d  = LAST_COL_D;
            col2_d = LAST_COL_D;
            sfrac  = '0;
        end
        else
        begin
            col_d  = ws_sat[14:8];
            col2_d = ws_sat[14:8] + 7'd1;
            sfrac  = ws_sat[7:0];
        end

        wr_ok = (32'(a_row_reg) <= 32'(LAST_ROW)) && (32'(a_col_reg) <= 32'(LAST_COL));
    end

    assign job_vld          = a_vld_reg;
    assign job_ctl.is_write = (a_type_reg == REQ_WRITE);
    assign job_ctl.wr_ok    = wr_ok;
    assign job_ctl.afrac    = afrac;
    assign job_ctl.sfrac    = sfrac;
    assign job_row          = (a_type_reg == REQ_WRITE) ? ROW_W'(a_row_reg) : ROW_W'(row_d);
    assign job_row2         = ROW_W'(row2_d);
    assign job_col          = (a_type_reg == REQ_WRITE) ? COL_W'(a_col_reg) : COL_W'(col_d);
    assign job_col2         = COL_W'(col2_d);
    assign job_wdata        = ENTRY_BITS'(a_val_reg);

endmodule

`default_nettype wire

/* rtl/pbl_issue.sv */
`timescale 1ns / 1ps
`default_nettype none

module pbl_issue #(
    parameter int ANGLE_ROWS    = 181,
    parameter int SPEED_COLUMNS = 61,
    parameter int ENTRY_BITS    = 16,
    localparam int ROW_W        = $clog2(ANGLE_ROWS),
    localparam int COL_W        = $clog2(SPEED_COLUMNS),
    localparam int ADDR_W       = $clog2(ANGLE_ROWS * SPEED_COLUMNS)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  job_vld,
    input  pbl_pkg::job_ctl_t     job_ctl,
    input  logic [ROW_W-1:0]      job_row,
    input  logic [ROW_W-1:0]      job_row2,
    input  logic [COL_W-1:0]      job_col,
    input  logic [COL_W-1:0]      job_col2,
    input  logic [ENTRY_BITS-1:0] job_wdata,
    input  logic                  result_pop,
    output logic                  take,
    output logic                  mem_we,
    output logic [ADDR_W-1:0]     mem_addr,
    output logic [ENTRY_BITS-1:0] mem_wdata,
    output pbl_pkg::rd_tag_t      mem_tag
);

    import pbl_pkg::*;

    logic                  j_vld_reg, j_vld_next;
    job_ctl_t              j_ctl_reg;
    logic [ROW_W-1:0]      j_row_reg;
    logic [ROW_W-1:0]      j_row2_reg;
    logic [COL_W-1:0]      j_col_reg;
    logic [COL_W-1:0]      j_col2_reg;
    logic [ENTRY_BITS-1:0] j_wdata_reg;
    logic [1:0]            step_reg, step_next;
    logic [QCNT_W-1:0]     pend_reg, pend_next;

    logic             issue_ok;
    logic             done;
    logic             start;
    logic [ROW_W-1:0] sel_row;
    logic [COL_W-1:0] sel_col;

    assign issue_ok = j_vld_reg && (j_ctl_reg.is_write || (step_reg != STEP_R0C0) ||
                                    (32'(pend_reg) < 32'(QDEPTH)));
    assign done     = issue_ok && (j_ctl_reg.is_write || (step_reg == STEP_R1C1));
    assign start    = issue_ok && !j_ctl_reg.is_write && (step_reg == STEP_R0C0);
    assign take     = job_vld && (!j_vld_reg || done);

    always_comb
    begin
        j_vld_next = take ? 1'b1 : (done ? 1'b0 : j_vld_reg);
        step_next  = (issue_ok && !j_ctl_reg.is_write) ? step_reg + 2'd1 : step_reg;
        pend_next  = pend_reg + QCNT_W'(start) - QCNT_W'(result_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            j_vld_reg <= 1'b0;
            step_reg  <= STEP_R0C0;
            pend_reg  <= '0;
        end
        else
        begin
            j_vld_reg <= j_vld_next;
            step_reg  <= step_next;
            pend_reg  <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            j_ctl_reg   <= job_ctl;
            j_row_reg   <= job_row;
            j_row2_reg  <= job_row2;
            j_col_reg   <= job_col;
            j_col2_reg  <= job_col2;
            j_wdata_reg <= job_wdata;
        end
    end

    always_comb
    begin
        sel_row = step_reg[0] ? j_row2_reg : j_row_reg;
        sel_col = step_reg[1] ? j_col2_reg : j_col_reg;
        if (j_ctl_reg.is_write)
        begin
            sel_row = j_row_reg;
            sel_col = j_col_reg;
        end
    end

    assign mem_addr      = ADDR_W'(32'(sel_row) * 32'(SPEED_COLUMNS) + 32'(sel_col));
    assign mem_we        = issue_ok && j_ctl_reg.is_write && j_ctl_reg.wr_ok;
    assign mem_wdata     = j_wdata_reg;
    assign mem_tag.vld   = issue_ok && !j_ctl_reg.is_write;
    assign mem_tag.step  = step_reg;
    assign mem_tag.afrac = j_ctl_reg.afrac;
    assign mem_tag.sfrac = j_ctl_reg.sfrac;

endmodule

`default_nettype wire

/* rtl/pbl_table.sv */
`timescale 1ns / 1ps
`default_nettype none

module pbl_table #(
    parameter int ANGLE_ROWS    = 181,
    parameter int SPEED_COLUMNS = 61,
    parameter int ENTRY_BITS    = 16,
    localparam int DEPTH        = ANGLE_ROWS * SPEED_COLUMNS,
    localparam int ADDR_W       = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [ADDR_W-1:0]     addr,
    input  logic [ENTRY_BITS-1:0] wdata,
    input  pbl_pkg::rd_tag_t      tag_in,
    output logic [ENTRY_BITS-1:0] rdata,
    output pbl_pkg::rd_tag_t      tag_out
);

    import pbl_pkg::*;

    logic [ENTRY_BITS-1:0] mem [DEPTH];
    logic [ENTRY_BITS-1:0] rdata_reg;
    rd_tag_t               tag_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata_reg <= mem[addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_reg <= '0;
        end
        else
        begin
            tag_reg <= tag_in;
        end
    end

    assign rdata   = rdata_reg;
    assign tag_out = tag_reg;

endmodule

`default_nettype wire

/* rtl/pbl_interp.sv */
`timescale 1ns / 1ps
`default_nettype none

module pbl_interp #(
    parameter int ENTRY_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [ENTRY_BITS-1:0] rdata,
    input  pbl_pkg::rd_tag_t      tag,
    input  logic                  pop,
    output logic                  out_valid,
    output logic [15:0]           boat_speed
);

    import pbl_pkg::*;

    localparam int DW   = ENTRY_BITS + 1;
    localparam int AP_W = DW + AFRAC_W + 1;
    localparam int SP_W = DW + SFRAC_W + 1;

    logic [ENTRY_BITS-1:0] hold_reg;
    logic [ENTRY_BITS-1:0] lo_reg;
    logic [ENTRY_BITS-1:0] lo2_reg;
    logic [ENTRY_BITS-1:0] hi_reg;
    logic [SFRAC_W-1:0]    sf_reg;
    logic                  fin_vld_reg;

    logic [15:0]       q_mem [QDEPTH];
    logic [QPTR_W-1:0] q_wr_reg, q_wr_next;
    logic [QPTR_W-1:0] q_rd_reg, q_rd_next;
    logic [QCNT_W-1:0] q_cnt_reg, q_cnt_next;

    logic signed [DW-1:0]      adiff;
    logic signed [AFRAC_W:0]   af_s;
    logic signed [AP_W-1:0]    aprod;
    logic signed [AP_W-1:0]    ashift;
    logic [ENTRY_BITS-1:0]     abl;
    logic signed [DW-1:0]      sdiff;
    logic signed [SFRAC_W:0]   sf_s;
    logic signed [SP_W-1:0]    sprod;
    logic signed [SP_W-1:0]    sshift;
    logic [ENTRY_BITS-1:0]     fres;
    logic [31:0]               fres_w;

    always_comb
    begin
        adiff  = $signed({1'b0, rdata}) - $signed({1'b0, hold_reg});
        af_s   = $signed({1'b0, tag.afrac});
        aprod  = adiff * af_s;
        ashift = aprod >>> AFRAC_W;
        abl    = hold_reg + ashift[ENTRY_BITS-1:0];

        sdiff  = $signed({1'b0, hi_reg}) - $signed({1'b0, lo2_reg});
        sf_s   = $signed({1'b0, sf_reg});
        sprod  = sdiff * sf_s;
        sshift = sprod >>> SFRAC_W;
        fres   = lo2_reg + sshift[ENTRY_BITS-1:0];
        fres_w = 32'(fres);
    end

    always_ff @(posedge clk)
    begin
        if (tag.vld && ((tag.step == STEP_R0C0) || (tag.step == STEP_R0C1)))
        begin
            hold_reg <= rdata;
        end
        if (tag.vld && (tag.step == STEP_R1C0))
        begin
            lo_reg <= abl;
        end
        if (tag.vld && (tag.step == STEP_R1C1))
        begin
            hi_reg  <= abl;
            lo2_reg <= lo_reg;
            sf_reg  <= tag.sfrac;
        end
        if (fin_vld_reg)
        begin
            q_mem[q_wr_reg] <= fres_w[15:0];
        end
    end

    always_comb
    begin
        q_wr_next  = fin_vld_reg ? q_wr_reg + QPTR_W'(1) : q_wr_reg;
        q_rd_next  = pop ? q_rd_reg + QPTR_W'(1) : q_rd_reg;
        q_cnt_next = q_cnt_reg + QCNT_W'(fin_vld_reg) - QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fin_vld_reg <= 1'b0;
            q_wr_reg    <= '0;
            q_rd_reg    <= '0;
            q_cnt_reg   <= '0;
        end
        else
        begin
            fin_vld_reg <= tag.vld && (tag.step == STEP_R1C1);
            q_wr_reg    <= q_wr_next;
            q_rd_reg    <= q_rd_next;
            q_cnt_reg   <= q_cnt_next;
        end
    end

    assign out_valid  = (q_cnt_reg != '0);
    assign boat_speed = q_mem[q_rd_reg];

endmodule

`default_nettype wire

/* rtl/polar_bilinear_lookup.sv */
`timescale 1ns / 1ps
`default_nettype none

// Polar speed table with bilinear lookup. A write request stores one Q8.8 boat speed
// at a whole-degree row and whole-knot column in a single table access, so writes can
// stream at one per cycle while no lookup holds the issue stage. A lookup request
// folds the binary wind angle into 0..180 degrees, saturates the wind speed at the
// last column and reads four neighboring entries from the single-port table memory,
// one per cycle; a new lookup starts only after the last one's four reads are issued.
// Results leave in request order through a four-entry output queue, so the block keeps
// accepting requests while a result waits. With round_angle_mode set, the angle is
// rounded to the nearest degree and only wind speed is interpolated. The table is not
// cleared after reset; every entry must be written before it is looked up. Write
// round_angle_mode only while no lookup is in flight.

module polar_bilinear_lookup #(
    parameter int ANGLE_ROWS    = 181,
    parameter int SPEED_COLUMNS = 61,
    parameter int ENTRY_BITS    = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        req_type,
    input  logic [7:0]  angle_row,
    input  logic [5:0]  speed_column,
    input  logic [15:0] entry_value,
    input  logic [15:0] wind_bearing,
    input  logic [13:0] wind_knots,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [15:0] boat_speed,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        round_angle_mode
);

    import pbl_pkg::*;

    localparam int ROW_W  = $clog2(ANGLE_ROWS);
    localparam int COL_W  = $clog2(SPEED_COLUMNS);
    localparam int ADDR_W = $clog2(ANGLE_ROWS * SPEED_COLUMNS);

    logic                  mode_reg;
    logic                  take;
    logic                  job_vld;
    job_ctl_t              job_ctl;
    logic [ROW_W-1:0]      job_row;
    logic [ROW_W-1:0]      job_row2;
    logic [COL_W-1:0]      job_col;
    logic [COL_W-1:0]      job_col2;
    logic [ENTRY_BITS-1:0] job_wdata;
    logic                  mem_we;
    logic [ADDR_W-1:0]     mem_addr;
    logic [ENTRY_BITS-1:0] mem_wdata;
    rd_tag_t               mem_tag;
    logic [ENTRY_BITS-1:0] rd_data;
    rd_tag_t               rd_tag;
    logic                  result_pop;

    assign cfg_ready  = 1'b1;
    assign result_pop = out_valid && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            mode_reg <= round_angle_mode;
        end
    end

    pbl_front #(
        .ANGLE_ROWS    (ANGLE_ROWS),
        .SPEED_COLUMNS (SPEED_COLUMNS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .angle_row    (angle_row),
        .speed_column (speed_column),
        .entry_value  (entry_value),
        .wind_bearing (wind_bearing),
        .wind_knots   (wind_knots),
        .mode         (mode_reg),
        .take         (take),
        .job_vld      (job_vld),
        .job_ctl      (job_ctl),
        .job_row      (job_row),
        .job_row2     (job_row2),
        .job_col      (job_col),
        .job_col2     (job_col2),
        .job_wdata    (job_wdata)
    );

    pbl_issue #(
        .ANGLE_ROWS    (ANGLE_ROWS),
        .SPEED_COLUMNS (SPEED_COLUMNS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .job_vld    (job_vld),
        .job_ctl    (job_ctl),
        .job_row    (job_row),
        .job_row2   (job_row2),
        .job_col    (job_col),
        .job_col2   (job_col2),
        .job_wdata  (job_wdata),
        .result_pop (result_pop),
        .take       (take),
        .mem_we     (mem_we),
        .mem_addr   (mem_addr),
        .mem_wdata  (mem_wdata),
        .mem_tag    (mem_tag)
    );

    pbl_table #(
        .ANGLE_ROWS    (ANGLE_ROWS),
        .SPEED_COLUMNS (SPEED_COLUMNS),
        .ENTRY_BITS    (ENTRY_BITS)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .we      (mem_we),
        .addr    (mem_addr),
        .wdata   (mem_wdata),
        .tag_in  (mem_tag),
        .rdata   (rd_data),
        .tag_out (rd_tag)
    );

    pbl_interp #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_interp (
        .clk        (clk),
        .rst_n      (rst_n),
        .rdata      (rd_data),
        .tag        (rd_tag),
        .pop        (result_pop),
        .out_valid  (out_valid),
        .boat_speed (boat_speed)
    );

endmodule

`default_nettype wire

/* rtl/pbl_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

module pbl_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_stall,
    input logic        req_type,
    input logic        out_valid,
    input logic        out_stall,
    input logic [15:0] boat_speed,
    input logic        cfg_valid,
    input logic        cfg_ready
);

    import pbl_pkg::*;

    localparam int CNT_W = $clog2(MAX_OUTSTANDING + 2);

    logic [CNT_W-1:0] outst_reg, outst_next;
    logic             lookup_in;
    logic             result_out;

    assign lookup_in  = in_valid && !in_stall && (req_type == REQ_LOOKUP);
    assign result_out = out_valid && !out_stall;
    assign outst_next = outst_reg + CNT_W'(lookup_in) - CNT_W'(result_out);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outst_reg <= '0;
        end
        else
        begin
            outst_reg <= outst_next;
        end
    end

    // A stalled result stays offered and unchanged.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(boat_speed))
        else $error("stalled result changed or dropped");

    // Every result belongs to a lookup request that has not yet been answered.
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (outst_reg != '0))
        else $error("result without a pending lookup request");

    // Backpressure bounds the lookups held inside the block.
    a_bound: assert property (@(posedge clk) disable iff (!rst_n)
        int'(outst_reg) <= MAX_OUTSTANDING)
        else $error("too many lookup requests in flight");

    // Configuration writes are never refused.
    a_cfg: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid |-> cfg_ready)
        else $error("configuration write refused");

endmodule

bind polar_bilinear_lookup pbl_checker u_checker (.*);

`default_nettype wire

/* bench/tb_polar_bilinear_lookup.sv */
`timescale 1ns / 1ps

module tb_polar_bilinear_lookup;
    import pbl_pkg::*;

    localparam int ROWS           = 181;
    localparam int COLS           = 61;
    localparam int LAST_ROW       = ROWS - 1;
    localparam int LAST_COL       = COLS - 1;
    localparam int SAT_SPEED      = LAST_COL * 256;
    localparam int SETTLE_CYCLES  = 24;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int PHASE_ITEMS    = 190;
    localparam int DIRECTED_LOOKUPS = 7;

    typedef struct {
        logic        kind;
        logic [7:0]  row;
        logic [5:0]  col;
        logic [15:0] value;
        logic [15:0] angle;
        logic [13:0] speed;
    } polar_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic        req_type = REQ_WRITE;
    logic [7:0]  angle_row = '0;
    logic [5:0]  speed_column = '0;
    logic [15:0] entry_value = '0;
    logic [15:0] wind_bearing = '0;
    logic [13:0] wind_knots = '0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [15:0] boat_speed;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        round_angle_mode = 1'b0;

    polar_req_t  pending_reqs[$];
    polar_req_t  staged_req;
    logic [15:0] speed_expect[$];
    logic [15:0] expected_speed;
    logic [15:0] speed_model [0:ROWS-1][0:COLS-1];
    bit          entry_loaded [0:ROWS-1][0:COLS-1];

    logic pred_mode = 1'b0;
    logic cfg_req = 1'b0;
    logic cfg_data = 1'b0;
    logic cfg_ack = 1'b0;
    logic hold_trigger = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;
    int   idle_in_pct = 0;
    int   idle_out_pct = 0;
    int   items_added = 0;
    int   fail_count = 0;
    int   quiet_cycles = 0;

    polar_bilinear_lookup #(
        .ANGLE_ROWS   (ROWS),
        .SPEED_COLUMNS(COLS),
        .ENTRY_BITS   (16)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .req_type        (req_type),
        .angle_row       (angle_row),
        .speed_column    (speed_column),
        .entry_value     (entry_value),
        .wind_bearing    (wind_bearing),
        .wind_knots      (wind_knots),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .boat_speed      (boat_speed),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .round_angle_mode(round_angle_mode)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic logic [15:0] blend(input logic [15:0] a, input logic [15:0] b,
                                          input int unsigned f, input int sh);
        longint unsigned w;
        longint unsigned s;
        w = 64'd1 << sh;
        s = a * (w - f) + b * f;
        return 16'(s >> sh);
    endfunction

    function automatic logic [15:0] predict_speed(input logic [15:0] ang,
                                                  input logic [13:0] ws, input logic mode);
        int unsigned w;
        int unsigned col;
        int unsigned col2;
        int unsigned sfrac;
        int unsigned row;
        int unsigned row2;
        int unsigned afrac;
        int unsigned a;
        int unsigned t;
        logic [15:0] lo;
        logic [15:0] hi;
        w = (ws > SAT_SPEED) ? SAT_SPEED : ws;
        col = w >> 8;
        sfrac = w & 8'hFF;
        if (col >= LAST_COL)
        begin
            col = LAST_COL;
            sfrac = 0;
            col2 = col;
        end
        else
        begin
            col2 = col + 1;
        end
        if (mode)
        begin
            row = (ang * 360 + 32768) >> 16;
            if (row > 180)
                row = 360 - row;
            if (row > LAST_ROW)
                row = LAST_ROW;
            lo = speed_model[row][col];
            hi = speed_model[row][col2];
        end
        else
        begin
            a = ang;
            if (a > 32768)
                a = 65536 - a;
            t = a * 360;
            row = t >> 16;
            afrac = t & 16'hFFFF;
            if (row >= LAST_ROW)
            begin
                row = LAST_ROW;
                afrac = 0;
                row2 = LAST_ROW - 1;
            end
            else
            begin
                row2 = row + 1;
            end
            lo = blend(speed_model[row][col], speed_model[row2][col], afrac, 16);
            hi = blend(speed_model[row][col2], speed_model[row2][col2], afrac, 16);
        end
        return blend(lo, hi, sfrac, 8);
    endfunction

    task automatic push_write(input logic [7:0] row, input logic [5:0] col,
                              input logic [15:0] value);
        polar_req_t r;
        r.kind = REQ_WRITE;
        r.row = row;
        r.col = col;
        r.value = value;
        r.angle = 16'($urandom);
        r.speed = 14'($urandom);
        pending_reqs.push_back(r);
        items_added++;
        if (row <= LAST_ROW && col <= LAST_COL)
        begin
            entry_loaded[row][col] = 1'b1;
        end
    endtask

    // Every entry that either angle mode could read is loaded before the lookup is sent.
    task automatic push_lookup(input logic [15:0] angle, input logic [13:0] speed);
        int unsigned w;
        int unsigned a;
        int unsigned rows[4];
        int unsigned cols[2];
        polar_req_t r;
        w = (speed > SAT_SPEED) ? SAT_SPEED : speed;
        cols[0] = w >> 8;
        cols[1] = (cols[0] < LAST_COL) ? cols[0] + 1 : cols[0];
        a = (angle > 32768) ? 65536 - angle : angle;
        rows[0] = (a * 360) >> 16;
        rows[1] = (rows[0] < LAST_ROW) ? rows[0] + 1 : LAST_ROW - 1;
        rows[2] = (angle * 360 + 32768) >> 16;
        if (rows[2] > 180)
            rows[2] = 360 - rows[2];
        rows[3] = (rows[2] < LAST_ROW) ? rows[2] + 1 : LAST_ROW - 1;
        foreach (rows[i])
            foreach (cols[j])
                if (!entry_loaded[rows[i]][cols[j]])
                    push_write(8'(rows[i]), 6'(cols[j]), 16'($urandom));
        r.kind = REQ_LOOKUP;
        r.row = 8'($urandom);
        r.col = 6'($urandom);
        r.value = 16'($urandom);
        r.angle = angle;
        r.speed = speed;
        pending_reqs.push_back(r);
        items_added++;
    endtask

    task automatic drain_and_settle();
        while (pending_reqs.size() != 0 || in_valid || speed_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_mode(input logic mode);
        drain_and_settle();
        cfg_data = mode;
        cfg_req = 1'b1;
        while (!cfg_ack)
            @(negedge clk);
        cfg_req = 1'b0;
        while (cfg_ack)
            @(negedge clk);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_valid <= 1'b0;
            cfg_ack <= 1'b0;
            pred_mode <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            pred_mode <= round_angle_mode;
            cfg_valid <= 1'b0;
            cfg_ack <= 1'b1;
        end
        else if (!cfg_req)
        begin
            cfg_ack <= 1'b0;
        end
        else if (!cfg_valid && !cfg_ack)
        begin
            cfg_valid <= 1'b1;
            round_angle_mode <= cfg_data;
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                if (req_type == REQ_WRITE)
                begin
                    if (angle_row <= LAST_ROW && speed_column <= LAST_COL)
                        speed_model[angle_row][speed_column] = entry_value;
                end
                else
                begin
                    speed_expect.push_back(predict_speed(wind_bearing, wind_knots, pred_mode));
                end
            end
            if (!in_valid || !in_stall)
            begin
                if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= idle_in_pct)
                begin
                    staged_req = pending_reqs.pop_front();
                    in_valid <= 1'b1;
                    req_type <= staged_req.kind;
                    angle_row <= staged_req.row;
                    speed_column <= staged_req.col;
                    entry_value <= staged_req.value;
                    wind_bearing <= staged_req.angle;
                    wind_knots <= staged_req.speed;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
            hold_left <= 0;
            hold_seen <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (speed_expect.size() == 0)
                begin
                    $error("boat_speed: no result expected, actual %h", boat_speed);
                    fail_count++;
                end
                else
                begin
                    expected_speed = speed_expect.pop_front();
                    if (boat_speed !== expected_speed)
                    begin
                        $error("boat_speed: expected %h, actual %h", expected_speed, boat_speed);
                        fail_count++;
                    end
                end
            end
            if (hold_trigger && !hold_seen)
            begin
                hold_seen <= 1'b1;
                hold_left <= HOLD_CYCLES;
                out_stall <= 1'b1;
            end
            else if (hold_left != 0)
            begin
                hold_left <= hold_left - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < idle_out_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready)
            || (pending_reqs.size() == 0 && !in_valid && speed_expect.size() == 0
                && !cfg_valid))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("CHECKS FAILED");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin : stimulus
        logic [15:0] dir_angle [DIRECTED_LOOKUPS];
        logic [13:0] dir_speed [DIRECTED_LOOKUPS];
        int          pick;
        logic [15:0] ang;
        logic [13:0] spd;
        logic [15:0] val;

        dir_angle = '{16'h0000, 16'hFFFF, 16'h8000, 16'h7FFF, 16'h005B, 16'h005C, 16'hFFA5};
        dir_speed = '{14'h0000, 14'h3FFF, 14'(SAT_SPEED), 14'(SAT_SPEED - 1), 14'h0180,
                      14'h01FF, 14'h0080};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        write_mode(1'b0);
        push_write(8'd0, 6'd0, 16'h0000);
        push_write(8'd0, 6'd1, 16'hFFFF);
        push_write(8'd1, 6'd0, 16'hFFFF);
        push_write(8'd1, 6'd1, 16'h0000);
        push_write(8'd180, 6'd60, 16'hFFFF);
        push_write(8'd179, 6'd60, 16'h0000);
        push_write(8'd180, 6'd59, 16'h8001);
        push_write(8'd179, 6'd59, 16'h7FFE);
        push_write(8'hFF, 6'h3F, 16'hFFFF);
        push_write(8'd181, 6'd0, 16'h1234);
        push_write(8'd0, 6'd61, 16'h4321);
        for (int i = 0; i < DIRECTED_LOOKUPS; i++)
            push_lookup(dir_angle[i], dir_speed[i]);

        write_mode(1'b1);
        for (int i = 0; i < DIRECTED_LOOKUPS; i++)
            push_lookup(dir_angle[i], dir_speed[i]);

        for (int phase = 0; phase < 6; phase++)
        begin
            write_mode(phase[0]);
            case (phase / 2)
                0:
                begin
                    idle_in_pct = 25;
                    idle_out_pct = 87;
                end
                1:
                begin
                    idle_in_pct = 87;
                    idle_out_pct = 25;
                end
                default:
                begin
                    idle_in_pct = 0;
                    idle_out_pct = 0;
                end
            endcase
            items_added = 0;
            while (items_added < PHASE_ITEMS)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    ang = 16'($urandom);
                    spd = 14'($urandom);
                    if (pick < 6)
                        spd = 14'($urandom_range(SAT_SPEED - 256, SAT_SPEED + 256));
                    else if (pick < 12)
                        ang = 16'(32'h8000 + $urandom_range(0, 400) - 200);
                    push_lookup(ang, spd);
                end
                else if (pick < 92)
                begin
                    val = 16'($urandom);
                    if (pick >= 88)
                        val = pick[0] ? 16'hFFFF : 16'h0000;
                    push_write(8'($urandom_range(0, LAST_ROW)), 6'($urandom_range(0, LAST_COL)),
                               val);
                end
                else if (pick[0])
                begin
                    push_write(8'($urandom_range(ROWS, 255)), 6'($urandom), 16'($urandom));
                end
                else
                begin
                    push_write(8'($urandom), 6'($urandom_range(COLS, 63)), 16'($urandom));
                end
            end
            if (phase == 0)
                hold_trigger = 1'b1;
        end

        drain_and_settle();
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
